[sv/rar_pkg.sv]
// Package: shared constants, types and states of the relevance ranking core.
`default_nettype none
package rar_pkg;
  localparam int MAX_DOCS  = 64;
  localparam int MAX_TERMS = 4;
  localparam int NUM_TERM_REGS = 4;
  localparam int IDX_W   = $clog2(MAX_DOCS);
  localparam int CNT_W   = $clog2(MAX_DOCS + 1);
  localparam int ID_W    = 16;
  localparam int OCC_W   = 16;
  localparam int SCORE_W = 32;
  localparam int REL_W   = 17;
  localparam int MCNT_W  = $clog2(NUM_TERM_REGS + 1);
  localparam int ADD_W   = OCC_W + MCNT_W - 1;
  localparam int TOP_W   = 7;
  localparam int QCNT_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_STEP_W = $clog2(REL_W);

  localparam logic [CFG_IDX_W-1:0] REG_QTERM0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_QTERM1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_QTERM2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_QTERM3 = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_QCOUNT = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = CFG_IDX_W'(5);
  localparam logic OP_POST   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef struct packed {
    logic               start;
    logic [SCORE_W-1:0] num;
    logic [SCORE_W-1:0] den;
  } div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SRCH_RD, ST_SRCH_CMP, ST_NEW, ST_SC_RD, ST_SC_WR,
    ST_MAX_RD, ST_MAX_CMP, ST_DIV_RD, ST_DIV_GO, ST_DIV_WAIT,
    ST_INS_RD, ST_INS_CMP, ST_INS_PUT, ST_OUT_RD, ST_OUT_HOLD
  } state_t;
endpackage
`default_nettype wire

[sv/rar_div.sv]
// Restoring divider: floor(num * 2^16 / den), one quotient bit per cycle, num <= den.
`default_nettype none
module rar_div import rar_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire div_req_t         req,
  output logic                  done,
  output logic [REL_W-1:0]      quo
);
  logic                  busy;
  logic [DIV_STEP_W-1:0] step;
  logic [SCORE_W:0]      rem;
  logic [SCORE_W:0]      trial;
  logic [SCORE_W:0]      den_x;

  assign den_x = {1'b0, req.den};
  assign trial = (step == '0) ? rem : {rem[SCORE_W-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= {1'b0, req.num};
        quo  <= '0;
      end else if (busy) begin
        if (trial >= den_x) begin
          rem <= trial - den_x;
          quo <= {quo[REL_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[REL_W-2:0], 1'b0};
        end
        if (step == DIV_STEP_W'(REL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

[sv/relevance_accumulate_rank_core.sv]
// Top level: posting accumulation, max scan, per-entry divide, insertion sort, ranked output.
// Posting: a word that matches no query term is just accepted; else the table is searched
// entry by entry and the score updated or a new entry added. Finish: max scan, then per entry
// the shared divider and insertion sort, then ranked output. One word in flight at a time.
// Reset (rst, synchronous) clears entry count, dropped flag, config (top set to 10), not tables.
`default_nettype none
module relevance_accumulate_rank_core import rar_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [47:0]           s_tdata,   // doc_id, term_id, occurrences
  input  wire logic                  s_tuser,   // opcode
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [39:0]                m_tdata,   // result_doc_id, relevance, zero pad
  output logic                       m_tlast,   // last
  output logic                       m_tuser,   // overflowed
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  logic [ID_W-1:0]    qterm [NUM_TERM_REGS];
  logic [QCNT_W-1:0]  qcount;
  logic [TOP_W-1:0]   top;

  logic [ID_W-1:0]    doc_mem   [MAX_DOCS];
  logic [SCORE_W-1:0] score_mem [MAX_DOCS];
  logic [REL_W-1:0]   rel_mem   [MAX_DOCS];
  logic [ID_W-1:0]    id_mem    [MAX_DOCS];
  logic [ID_W-1:0]    doc_rd, id_rd;
  logic [SCORE_W-1:0] score_rd;
  logic [REL_W-1:0]   rel_rd;

  state_t state, state_next;
  logic [CNT_W-1:0]   cnt, idx, j, k, nout;
  logic               dropped;
  logic [ID_W-1:0]    doc_q, cur_id;
  logic [ADD_W-1:0]   add_q;
  logic [SCORE_W-1:0] maxs;
  logic [REL_W-1:0]   r_q;

  logic [MCNT_W-1:0]  match_n;
  logic [QCNT_W-1:0]  active;
  logic [SCORE_W:0]   sum;
  logic [IDX_W-1:0]   sort_ra;
  div_req_t           dreq;
  logic               ddone;
  logic [REL_W-1:0]   dquo;
  logic               s_acc, m_acc;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign m_tvalid  = (state == ST_OUT_HOLD);
  assign m_acc     = m_tvalid && m_tready;
  assign m_tdata   = {7'b0, rel_rd, id_rd};
  assign m_tlast   = (k + 1'b1 == nout);
  assign m_tuser   = dropped;

  assign active = (qcount > QCNT_W'(MAX_TERMS)) ? QCNT_W'(MAX_TERMS) : qcount;
  always_comb begin
    match_n = '0;
    for (int t = 0; t < NUM_TERM_REGS; t++) begin
      if (QCNT_W'(t) < active && qterm[t] == s_tdata[31:16]) begin
        match_n = match_n + 1'b1;
      end
    end
  end

  assign sum = {1'b0, score_rd} + (SCORE_W+1)'(add_q);
  assign sort_ra = (state == ST_INS_RD) ? IDX_W'(j - 1'b1) : k[IDX_W-1:0];

  assign dreq.start = (state == ST_DIV_GO);
  assign dreq.num   = score_rd;
  assign dreq.den   = maxs;

  rar_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (ddone),
    .quo  (dquo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < NUM_TERM_REGS; t++) qterm[t] <= '0;
      qcount <= '0;
      top    <= TOP_W'(10);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index < CFG_IDX_W'(NUM_TERM_REGS)) begin
        qterm[cfg_index[1:0]] <= cfg_data;
      end else if (cfg_index == REG_QCOUNT) begin
        qcount <= cfg_data[QCNT_W-1:0];
      end else if (cfg_index == REG_TOP) begin
        top <= cfg_data[TOP_W-1:0];
      end
    end
  end

  // table memories
  always_ff @(posedge clk) begin
    if (state == ST_NEW && cnt != CNT_W'(MAX_DOCS)) begin
      doc_mem[cnt[IDX_W-1:0]]   <= doc_q;
      score_mem[cnt[IDX_W-1:0]] <= SCORE_W'(add_q);
    end else if (state == ST_SC_WR) begin
      score_mem[idx[IDX_W-1:0]] <= sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];
    end
    doc_rd   <= doc_mem[idx[IDX_W-1:0]];
    score_rd <= score_mem[idx[IDX_W-1:0]];
  end

  // sorted memories
  always_ff @(posedge clk) begin
    if (state == ST_INS_CMP && rel_rd < r_q) begin
      rel_mem[j[IDX_W-1:0]] <= rel_rd;
      id_mem[j[IDX_W-1:0]]  <= id_rd;
    end else if (state == ST_INS_PUT) begin
      rel_mem[j[IDX_W-1:0]] <= r_q;
      id_mem[j[IDX_W-1:0]]  <= cur_id;
    end
    rel_rd <= rel_mem[sort_ra];
    id_rd  <= id_mem[sort_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_acc) begin
          if (s_tuser == OP_FINISH) begin
            if (cnt == '0) state_next = ST_IDLE;
            else           state_next = ST_MAX_RD;
          end else if (match_n != '0) begin
            state_next = (cnt == '0) ? ST_NEW : ST_SRCH_RD;
          end
        end
      end
      ST_SRCH_RD:  state_next = ST_SRCH_CMP;
      ST_SRCH_CMP: begin
        if (doc_rd == doc_q)         state_next = ST_SC_RD;
        else if (idx + 1'b1 == cnt)  state_next = ST_NEW;
        else                         state_next = ST_SRCH_RD;
      end
      ST_NEW:     state_next = ST_IDLE;
      ST_SC_RD:   state_next = ST_SC_WR;
      ST_SC_WR:   state_next = ST_IDLE;
      ST_MAX_RD:  state_next = ST_MAX_CMP;
      ST_MAX_CMP: state_next = (idx + 1'b1 == cnt) ? ST_DIV_RD : ST_MAX_RD;
      ST_DIV_RD:  state_next = ST_DIV_GO;
      ST_DIV_GO:  state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (ddone) state_next = (idx == '0) ? ST_INS_PUT : ST_INS_RD;
      end
      ST_INS_RD:  state_next = ST_INS_CMP;
      ST_INS_CMP: begin
        if (rel_rd < r_q && j != CNT_W'(1)) state_next = ST_INS_RD;
        else                                state_next = ST_INS_PUT;
      end
      ST_INS_PUT: begin
        if (idx + 1'b1 != cnt)                  state_next = ST_DIV_RD;
        else if (top == '0)                     state_next = ST_IDLE;
        else                                    state_next = ST_OUT_RD;
      end
      ST_OUT_RD:  state_next = ST_OUT_HOLD;
      ST_OUT_HOLD: begin
        if (m_acc) state_next = m_tlast ? ST_IDLE : ST_OUT_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      dropped <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          idx  <= '0;
          maxs <= '0;
          if (s_acc) begin
            doc_q <= s_tdata[15:0];
            add_q <= ADD_W'(match_n) * ADD_W'(s_tdata[47:32]);
            if (s_tuser == OP_FINISH && cnt == '0) dropped <= 1'b0;
          end
        end
        ST_SRCH_CMP: begin
          if (doc_rd != doc_q && idx + 1'b1 != cnt) idx <= idx + 1'b1;
        end
        ST_NEW: begin
          if (cnt == CNT_W'(MAX_DOCS)) dropped <= 1'b1;
          else                         cnt <= cnt + 1'b1;
        end
        ST_MAX_CMP: begin
          if (score_rd > maxs) maxs <= score_rd;
          idx <= (idx + 1'b1 == cnt) ? '0 : idx + 1'b1;
        end
        ST_DIV_GO: cur_id <= doc_rd;
        ST_DIV_WAIT: begin
          r_q <= (maxs == '0) ? '0 : dquo;
          j   <= idx;
        end
        ST_INS_CMP: begin
          if (rel_rd < r_q) j <= j - 1'b1;
        end
        ST_INS_PUT: begin
          if (idx + 1'b1 != cnt) begin
            idx <= idx + 1'b1;
          end else begin
            k    <= '0;
            nout <= (CNT_W'(top) < cnt && top < TOP_W'(MAX_DOCS + 1)) ? CNT_W'(top) : cnt;
            if (top == '0) begin
              cnt     <= '0;
              dropped <= 1'b0;
            end
          end
        end
        ST_OUT_HOLD: begin
          if (m_acc) begin
            k <= k + 1'b1;
            if (m_tlast) begin
              cnt     <= '0;
              dropped <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// Testbench: term-frequency scoring and top-k ranking checked against an inline predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import rar_pkg::*;

  localparam int LIMIT = 4000000;

  typedef struct packed {
    logic [15:0] doc_id;
    logic [16:0] relevance;
    logic        last;
    logic        overflowed;
  } rank_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic m_tlast;
  logic m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  relevance_accumulate_rank_core dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [15:0] q_term [NUM_TERM_REGS];
  logic [2:0]  q_count;
  logic [6:0]  top_n;
  logic [15:0] docs [MAX_DOCS];
  logic [31:0] scores [MAX_DOCS];
  int          n_docs;
  bit          dropped;

  rank_word_t ranking_q[$];
  int  errors = 0;
  int  cycles = 0;
  int  burst_left = 0;
  int  stall_mode = 0;

  function automatic void apply_posting(logic [15:0] doc, logic [15:0] term, logic [15:0] occ);
    int act;
    int pos;
    logic [32:0] sum;
    act = (q_count > MAX_TERMS) ? MAX_TERMS : q_count;
    for (int t = 0; t < act; t++) begin
      if (q_term[t] != term) continue;
      pos = n_docs;
      for (int i = 0; i < n_docs; i++)
        if (docs[i] == doc) begin
          pos = i;
          break;
        end
      if (pos == n_docs) begin
        if (n_docs >= MAX_DOCS) begin
          dropped = 1'b1;
          continue;
        end
        docs[pos] = doc;
        scores[pos] = '0;
        n_docs++;
      end
      sum = {1'b0, scores[pos]} + occ;
      scores[pos] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end
  endfunction

  function automatic void rank_finish();
    logic [31:0] maxs;
    logic [16:0] rel [MAX_DOCS];
    logic [15:0] ids [MAX_DOCS];
    logic [16:0] r;
    int j;
    int n;
    rank_word_t w;
    maxs = '0;
    for (int i = 0; i < n_docs; i++) if (scores[i] > maxs) maxs = scores[i];
    for (int i = 0; i < n_docs; i++) begin
      r = (maxs == 0) ? '0 : 17'(({16'd0, scores[i]} << 16) / {16'd0, maxs});
      j = i;
      while (j > 0 && rel[j-1] < r) begin
        rel[j] = rel[j-1];
        ids[j] = ids[j-1];
        j--;
      end
      rel[j] = r;
      ids[j] = docs[i];
    end
    n = top_n;
    if (n > n_docs) n = n_docs;
    if (n > 64) n = 64;
    for (int i = 0; i < n; i++) begin
      w.doc_id = ids[i];
      w.relevance = rel[i];
      w.last = (i + 1 == n);
      w.overflowed = dropped;
      ranking_q = {ranking_q, w};
    end
    n_docs = 0;
    dropped = 1'b0;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < CFG_IDX_W'(NUM_TERM_REGS)) q_term[idx[1:0]] = val;
    else if (idx == REG_QCOUNT) q_count = val[2:0];
    else if (idx == REG_TOP) top_n = val[6:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one input word; random gaps between bursts
  task automatic send_word(logic op, logic [15:0] doc, logic [15:0] term, logic [15:0] occ);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {occ, term, doc};
    do @(posedge clk); while (!s_tready);
    if (op == OP_FINISH) rank_finish();
    else apply_posting(doc, term, occ);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (ranking_q.size() != 0) @(negedge clk);
    repeat (20000) @(negedge clk);
  endtask

  task automatic set_query(logic [15:0] t0, t1, t2, t3, logic [2:0] cnt, logic [6:0] top);
    write_reg(REG_QTERM0, t0);
    write_reg(REG_QTERM1, t1);
    write_reg(REG_QTERM2, t2);
    write_reg(REG_QTERM3, t3);
    write_reg(REG_QCOUNT, 16'(cnt));
    write_reg(REG_TOP, 16'(top));
  endtask

  task automatic test_directed();
    set_query(16'd5, 16'hFFFF, 16'd5, 16'd0, 3'd4, 7'd10);
    send_word(OP_FINISH, 16'd0, 16'd0, 16'd0);
    send_word(OP_POST, 16'd1, 16'd7, 16'd3);
    send_word(OP_POST, 16'd1, 16'd5, 16'd3);
    send_word(OP_POST, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(OP_POST, 16'd2, 16'd0, 16'd0);
    send_word(OP_POST, 16'd3, 16'd0, 16'd6);
    send_word(OP_POST, 16'd0, 16'd5, 16'd0);
    send_word(OP_FINISH, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(OP_POST, 16'd9, 16'd0, 16'd0);
    send_word(OP_POST, 16'd8, 16'd0, 16'd0);
    send_word(OP_FINISH, 16'd0, 16'd0, 16'd0);
    drain();
    set_query(16'hAAAA, 16'h5555, 16'd0, 16'd0, 3'd7, 7'd0);
    send_word(OP_POST, 16'd4, 16'hAAAA, 16'd9);
    send_word(OP_FINISH, 16'd0, 16'd0, 16'd0);
    drain();
    set_query(16'd1, 16'd1, 16'd1, 16'd1, 3'd4, 7'd64);
    for (int i = 0; i < 3; i++) send_word(OP_POST, 16'd77, 16'd1, 16'hFFFF);
    for (int i = 0; i < 3000; i++) begin
      send_word(OP_POST, 16'd77, 16'd1, 16'hFFFF);
      if (i == 5) break;
    end
    send_word(OP_POST, 16'd78, 16'd1, 16'd1);
    send_word(OP_FINISH, 16'd0, 16'd0, 16'd0);
    drain();
  endtask

  // table overflow: 66 distinct docs, top count 127
  task automatic test_table_full();
    set_query(16'd3, 16'd0, 16'd0, 16'd0, 3'd1, 7'd127);
    for (int d = 0; d < 66; d++)
      send_word(OP_POST, 16'(d * 977), 16'd3, 16'($urandom_range(0, 40)));
    send_word(OP_FINISH, 16'd0, 16'd0, 16'd0);
    drain();
  endtask

  task automatic test_random();
    logic [15:0] terms [4];
    int sent;
    sent = 0;
    while (sent < 70) begin
      for (int k = 0; k < 4; k++) terms[k] = 16'($urandom);
      if ($urandom_range(0, 3) == 0) terms[1] = terms[0];
      set_query(terms[0], terms[1], terms[2], terms[3], 3'($urandom_range(0, 7)),
                7'($urandom_range(0, 3) == 0 ? $urandom_range(0, 127) : $urandom_range(1, 12)));
      for (int k = $urandom_range(1, 20); k > 0; k--) begin
        if ($urandom_range(0, 4) == 0)
          send_word(OP_POST, 16'($urandom), 16'($urandom), 16'($urandom));
        else
          send_word(OP_POST, 16'($urandom_range(0, 15)) ^ {16{$urandom_range(0, 9) == 0}},
                    terms[$urandom_range(0, 3)],
                    $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 9)));
        sent++;
      end
      send_word(OP_FINISH, 16'($urandom), 16'($urandom), 16'($urandom));
      sent++;
      drain();
    end
  endtask

  // receiver stall pattern: modes with no stalls, random and long stalls
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= $urandom_range(0, 1);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    rank_word_t exp_w;
    if (!rst && m_tvalid && m_tready) begin
      if (ranking_q.size() == 0) begin
        $error("unexpected result word doc_id=%0d", m_tdata[15:0]);
        errors++;
      end else begin
        exp_w = ranking_q.pop_front();
        if (m_tdata[15:0] !== exp_w.doc_id) begin
          $error("result_doc_id exp %0d got %0d", exp_w.doc_id, m_tdata[15:0]);
          errors++;
        end
        if (m_tdata[32:16] !== exp_w.relevance) begin
          $error("relevance exp %0d got %0d", exp_w.relevance, m_tdata[32:16]);
          errors++;
        end
        if (m_tlast !== exp_w.last) begin
          $error("last exp %0d got %0d", exp_w.last, m_tlast);
          errors++;
        end
        if (m_tuser !== exp_w.overflowed) begin
          $error("overflowed exp %0d got %0d", exp_w.overflowed, m_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    q_term = '{default: '0};
    q_count = '0;
    top_n = 7'd10;
    n_docs = 0;
    dropped = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_table_full();
    test_random();
    if (errors == 0 && ranking_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
sv/rar_pkg.sv
sv/rar_div.sv
sv/relevance_accumulate_rank_core.sv
tb/sv/tb_top.sv
